/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define M4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define M4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/m4inv_pkg.sv */
// ----------------------------------------------------------------------------
// m4inv_pkg
// types, constants and helpers shared by the 4x4 inverse controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package m4inv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 64 + FRAC_BITS;

    localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [4:0] {
        S_LOAD, S_RA, S_RB, S_RC, S_ML, S_MH, S_FN, S_XB, S_ACC, S_WMIN,
        S_DRA, S_DLD, S_DDONE, S_DIVLD, S_DCHK, S_DIT, S_DFIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {MD_MUL1, MD_MUL2, MD_DET} t_mode;

    typedef enum logic [1:0] {XS_NONE, XS_RD, XS_T, XS_MINOR} t_xsel;

    typedef enum logic [1:0] {ACC_HOLD, ACC_ADD, ACC_SUB, ACC_CLR} t_accop;

    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_addr;
        logic       rd_en;
        logic [3:0] rd_addr;
        t_xsel      x_sel;
        logic       b_ld;
        logic       mul_lo;
        logic       mul_hi;
        logic       fin;
        t_accop     acc_op;
        logic       sat_minor;
        logic [3:0] minor_idx;
        logic       minor_wr;
        logic       det_ld;
        logic       div_ld;
        logic       flip;
        logic       div_chk;
        logic       div_it;
        logic       div_fin;
        logic       out_sing;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
    } t_stat;

    // position within the 3x3 minor of operand j of product term t
    function automatic logic [3:0] term_k(input logic [2:0] t, input logic [1:0] j);
        logic [3:0] k;
        unique case (t)
            3'd0:    k = (j == 2'd0) ? 4'd0 : (j == 2'd1) ? 4'd4 : 4'd8;
            3'd1:    k = (j == 2'd0) ? 4'd1 : (j == 2'd1) ? 4'd5 : 4'd6;
            3'd2:    k = (j == 2'd0) ? 4'd2 : (j == 2'd1) ? 4'd3 : 4'd7;
            3'd3:    k = (j == 2'd0) ? 4'd2 : (j == 2'd1) ? 4'd4 : 4'd6;
            3'd4:    k = (j == 2'd0) ? 4'd1 : (j == 2'd1) ? 4'd3 : 4'd8;
            3'd5:    k = (j == 2'd0) ? 4'd0 : (j == 2'd1) ? 4'd5 : 4'd7;
            default: k = 4'd0;
        endcase
        return k;
    endfunction

    // store address of operand j of term t of the minor without row dr, column dc
    function automatic logic [3:0] term_addr(input logic [1:0] dr, input logic [1:0] dc,
                                             input logic [2:0] t, input logic [1:0] j);
        logic [3:0] k;
        logic [1:0] ri;
        logic [1:0] ci;
        logic [1:0] row;
        logic [1:0] col;
        k = term_k(t, j);
        unique case (k)
            4'd0:    begin ri = 2'd0; ci = 2'd0; end
            4'd1:    begin ri = 2'd0; ci = 2'd1; end
            4'd2:    begin ri = 2'd0; ci = 2'd2; end
            4'd3:    begin ri = 2'd1; ci = 2'd0; end
            4'd4:    begin ri = 2'd1; ci = 2'd1; end
            4'd5:    begin ri = 2'd1; ci = 2'd2; end
            4'd6:    begin ri = 2'd2; ci = 2'd0; end
            4'd7:    begin ri = 2'd2; ci = 2'd1; end
            4'd8:    begin ri = 2'd2; ci = 2'd2; end
            default: begin ri = 2'd0; ci = 2'd0; end
        endcase
        row = (ri >= dr) ? ri + 2'd1 : ri;
        col = (ci >= dc) ? ci + 2'd1 : ci;
        return {row, col};
    endfunction

endpackage

`default_nettype wire

/* rtl/matrix4_inverse_adjugate.sv */
// ----------------------------------------------------------------------------
// matrix4_inverse_adjugate
// 4x4 inverse by the adjugate in signed fixed point, saturating
//
//   channel  direction  handshake         payload
//   input    in         i_valid/o_stall   i_element
//   output   out        o_valid/i_stall   o_inv_element o_singular o_saturated o_last
//
// input beats take one cycle each while the store is free
// after the sixteenth beat the 16 minors and then the determinant are computed on
//   the shared multiplier, then each result beat comes from the one-bit-a-cycle
//   divider, or is given without the divider when singular
// input beats for the next matrix are taken while results drain, all but the last
// output stall holds the current result; synchronous active-low reset, no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_inverse_adjugate import m4inv_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_element,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_inv_element,
    output logic                    o_singular,
    output logic                    o_saturated,
    output logic                    o_last
);

    t_cmd  cmd;
    t_stat stat;

    m4inv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    m4inv_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_element     (i_element),
        .o_stat        (stat),
        .o_inv_element (o_inv_element),
        .o_singular    (o_singular),
        .o_saturated   (o_saturated),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* rtl/m4inv_dp.sv */
// ----------------------------------------------------------------------------
// m4inv_dp
// matrix store, shared 64x32 multiplier, saturating accumulator, minor
// registers and the bit-serial divider for the inverse elements
// ----------------------------------------------------------------------------
`default_nettype none

module m4inv_dp import m4inv_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_cmd               i_cmd,
    input  wire logic signed [31:0] i_element,
    output t_stat                   o_stat,
    output logic signed [31:0]      o_inv_element,
    output logic                    o_singular,
    output logic                    o_saturated,
    output logic                    o_last
);

    logic [31:0] r_mem [16];
    logic [31:0] r_rd;

    logic [63:0] r_xmag;
    logic        r_xneg;
    logic [31:0] r_bmag;
    logic        r_bneg;
    logic [95:0] r_prod;
    logic [63:0] r_tmag;
    logic        r_tneg;
    logic [63:0] r_tval;
    logic [63:0] r_acc;
    logic        r_sat;

    logic [63:0] r_minor [16];
    logic        r_msat  [16];

    logic [63:0] r_det;
    logic        r_dneg;
    logic        r_dsat;
    logic [63:0] r_den;

    logic [NUM_W-1:0] r_num;
    logic             r_qneg;
    logic             r_esat;
    logic             r_ovf;
    logic [63:0]      r_rem;
    logic [31:0]      r_lo;

    logic signed [31:0] r_out_elem;
    logic               r_out_sing;
    logic               r_out_sat;
    logic               r_out_last;

    logic        rd_neg;
    logic [31:0] rd_mag;
    logic [63:0] m_val;
    logic        m_neg;
    logic [63:0] m_mag;
    logic        p_neg;
    logic [95:0] sh;
    logic [63:0] mq_lim;
    logic        mq_over;
    logic [63:0] mq_mag;
    logic [63:0] mq_val;
    logic [64:0] sum;
    logic        acc_over;
    logic [63:0] acc_res;
    logic        m_is_min;
    logic        cof_neg;
    logic [63:0] cof_mag;
    logic        neg_sat;
    logic [63:0] top;
    logic [64:0] t65;
    logic        ge;
    logic [31:0] lim32;
    logic        clip;
    logic [31:0] qv;

    always_comb begin
        rd_neg   = r_rd[31];
        rd_mag   = rd_neg ? (32'd0 - r_rd) : r_rd;
        m_val    = r_minor[i_cmd.minor_idx];
        m_neg    = m_val[63];
        m_mag    = m_neg ? (64'd0 - m_val) : m_val;
        p_neg    = r_xneg ^ r_bneg;
        sh       = r_prod >> FRAC_BITS;
        mq_lim   = p_neg ? S64_MIN : S64_MAX;
        mq_over  = (|sh[95:64]) || (sh[63:0] > mq_lim);
        mq_mag   = mq_over ? mq_lim : sh[63:0];
        mq_val   = p_neg ? (64'd0 - mq_mag) : mq_mag;
        sum      = (i_cmd.acc_op == ACC_SUB) ? ({r_acc[63], r_acc} - {r_tval[63], r_tval})
                                             : ({r_acc[63], r_acc} + {r_tval[63], r_tval});
        acc_over = sum[64] != sum[63];
        acc_res  = acc_over ? (sum[64] ? S64_MIN : S64_MAX) : sum[63:0];
        m_is_min = m_val == S64_MIN;
        cof_neg  = i_cmd.flip ? (!m_neg && (m_val != 64'd0)) : m_neg;
        cof_mag  = (i_cmd.flip && m_is_min) ? S64_MAX : m_mag;
        neg_sat  = i_cmd.flip && m_is_min;
        top      = 64'(r_num[NUM_W-1:32]);
        t65      = {r_rem, r_lo[31]};
        ge       = t65 >= {1'b0, r_den};
        lim32    = r_qneg ? S32_MIN : S32_MAX;
        clip     = r_ovf || (r_lo > lim32);
        qv       = clip ? lim32 : r_lo;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_element;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.x_sel)
            XS_RD:    begin r_xmag <= {32'd0, rd_mag}; r_xneg <= rd_neg; end
            XS_T:     begin r_xmag <= r_tmag; r_xneg <= r_tneg; end
            XS_MINOR: begin r_xmag <= m_mag; r_xneg <= m_neg; end
            XS_NONE:  ;
        endcase
        if (i_cmd.b_ld) begin
            r_bmag <= rd_mag;
            r_bneg <= rd_neg;
        end
        if (i_cmd.mul_lo) begin
            r_prod <= {32'd0, 64'(r_xmag[31:0]) * 64'(r_bmag)};
        end else if (i_cmd.mul_hi) begin
            r_prod[95:32] <= r_prod[95:32] + 64'(r_xmag[63:32]) * 64'(r_bmag);
        end
        if (i_cmd.fin) begin
            r_tmag <= mq_mag;
            r_tneg <= p_neg;
            r_tval <= mq_val;
        end
        unique case (i_cmd.acc_op)
            ACC_CLR:          r_acc <= 64'd0;
            ACC_ADD, ACC_SUB: r_acc <= acc_res;
            ACC_HOLD:         ;
        endcase
        if (i_cmd.acc_op == ACC_CLR) begin
            r_sat <= 1'b0;
        end else begin
            r_sat <= r_sat | (i_cmd.fin & mq_over)
                           | ((i_cmd.acc_op != ACC_HOLD) & acc_over)
                           | (i_cmd.sat_minor & r_msat[i_cmd.minor_idx]);
        end
        if (i_cmd.minor_wr) begin
            r_minor[i_cmd.minor_idx] <= r_acc;
            r_msat[i_cmd.minor_idx]  <= r_sat;
        end
        if (i_cmd.det_ld) begin
            r_det  <= r_acc;
            r_dneg <= r_acc[63];
            r_dsat <= r_sat;
            r_den  <= r_acc[63] ? (64'd0 - r_acc) : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_ld) begin
            r_num  <= NUM_W'(cof_mag) << FRAC_BITS;
            r_qneg <= cof_neg ^ r_dneg;
            r_esat <= r_dsat | r_msat[i_cmd.minor_idx] | neg_sat;
        end
        if (i_cmd.div_chk) begin
            r_ovf <= top >= r_den;
            r_rem <= top;
            r_lo  <= r_num[31:0];
        end else if (i_cmd.div_it) begin
            r_rem <= ge ? 64'(t65 - {1'b0, r_den}) : t65[63:0];
            r_lo  <= {r_lo[30:0], ge};
        end
        if (i_cmd.div_fin) begin
            r_out_elem <= r_qneg ? (32'd0 - qv) : qv;
            r_out_sing <= 1'b0;
            r_out_sat  <= r_esat | clip;
            r_out_last <= i_cmd.last;
        end else if (i_cmd.out_sing) begin
            r_out_elem <= 32'd0;
            r_out_sing <= 1'b1;
            r_out_sat  <= 1'b0;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_stat.det_zero = r_det == 64'd0;
    assign o_inv_element   = r_out_elem;
    assign o_singular      = r_out_sing;
    assign o_saturated     = r_out_sat;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

/* rtl/m4inv_ctrl.sv */
// ----------------------------------------------------------------------------
// m4inv_ctrl
// sequencer for loading, minors, determinant, division and result beats
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module m4inv_ctrl import m4inv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  wire logic  i_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    t_mode      r_mode, n_mode;
    logic [3:0] r_cnt, n_cnt;
    logic [3:0] r_mi, n_mi;
    logic [2:0] r_term, n_term;
    logic [4:0] r_it, n_it;

    logic store_free;
    logic in_acc;

    always_comb begin
        store_free = (r_state == S_LOAD) || (r_state == S_DDONE) || (r_state == S_DIVLD)
                  || (r_state == S_DCHK) || (r_state == S_DIT) || (r_state == S_DFIN)
                  || (r_state == S_OUT);
        o_stall    = !(store_free && ((r_cnt != 4'd15) || (r_state == S_LOAD)));
        in_acc     = i_valid && !o_stall;
        o_valid    = r_state == S_OUT;
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_cnt   = in_acc ? r_cnt + 4'd1 : r_cnt;
        n_mi    = r_mi;
        n_term  = r_term;
        n_it    = r_it;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && (r_cnt == 4'd15)) begin
                    n_state = S_RA;
                    n_mi    = 4'd0;
                    n_term  = 3'd0;
                    n_mode  = MD_MUL1;
                end
            end
            S_RA: n_state = S_RB;
            S_RB: n_state = S_RC;
            S_RC: n_state = S_ML;
            S_ML: n_state = S_MH;
            S_MH: n_state = S_FN;
            S_FN: n_state = (r_mode == MD_MUL1) ? S_XB : S_ACC;
            S_XB: begin
                n_mode  = MD_MUL2;
                n_state = S_ML;
            end
            S_ACC: begin
                if (r_mode == MD_DET) begin
                    if (r_mi[1:0] == 2'd3) begin
                        n_state = S_DDONE;
                    end else begin
                        n_mi    = r_mi + 4'd1;
                        n_state = S_DRA;
                    end
                end else if (r_term == 3'd5) begin
                    n_state = S_WMIN;
                end else begin
                    n_term  = r_term + 3'd1;
                    n_mode  = MD_MUL1;
                    n_state = S_RA;
                end
            end
            S_WMIN: begin
                if (r_mi == 4'd15) begin
                    n_mi    = 4'd0;
                    n_mode  = MD_DET;
                    n_state = S_DRA;
                end else begin
                    n_mi    = r_mi + 4'd1;
                    n_term  = 3'd0;
                    n_mode  = MD_MUL1;
                    n_state = S_RA;
                end
            end
            S_DRA: n_state = S_DLD;
            S_DLD: n_state = S_ML;
            S_DDONE: begin
                n_mi    = 4'd0;
                n_state = S_DIVLD;
            end
            S_DIVLD: n_state = i_stat.det_zero ? S_OUT : S_DCHK;
            S_DCHK: begin
                n_it    = 5'd0;
                n_state = S_DIT;
            end
            S_DIT: begin
                if (r_it == 5'd31) begin
                    n_state = S_DFIN;
                end else begin
                    n_it = r_it + 5'd1;
                end
            end
            S_DFIN: n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    if (r_mi == 4'd15) begin
                        n_state = S_LOAD;
                    end else begin
                        n_mi    = r_mi + 4'd1;
                        n_state = S_DIVLD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.wr_en   = in_acc;
        o_cmd.wr_addr = r_cnt;
        unique case (r_state)
            S_LOAD: o_cmd.acc_op = ACC_CLR;
            S_RA: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = term_addr(r_mi[3:2], r_mi[1:0], r_term, 2'd0);
            end
            S_RB: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = term_addr(r_mi[3:2], r_mi[1:0], r_term, 2'd1);
                o_cmd.x_sel   = XS_RD;
            end
            S_RC: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = term_addr(r_mi[3:2], r_mi[1:0], r_term, 2'd2);
                o_cmd.b_ld    = 1'b1;
            end
            S_ML: o_cmd.mul_lo = 1'b1;
            S_MH: o_cmd.mul_hi = 1'b1;
            S_FN: o_cmd.fin    = 1'b1;
            S_XB: begin
                o_cmd.x_sel = XS_T;
                o_cmd.b_ld  = 1'b1;
            end
            S_ACC: begin
                if (r_mode == MD_DET) begin
                    o_cmd.acc_op = r_mi[0] ? ACC_SUB : ACC_ADD;
                end else begin
                    o_cmd.acc_op = (r_term < 3'd3) ? ACC_ADD : ACC_SUB;
                end
            end
            S_WMIN: begin
                o_cmd.minor_wr  = 1'b1;
                o_cmd.minor_idx = r_mi;
                o_cmd.acc_op    = ACC_CLR;
            end
            S_DRA: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = {r_mi[1:0], 2'b00};
            end
            S_DLD: begin
                o_cmd.b_ld      = 1'b1;
                o_cmd.x_sel     = XS_MINOR;
                o_cmd.minor_idx = {r_mi[1:0], 2'b00};
                o_cmd.sat_minor = 1'b1;
            end
            S_DDONE: o_cmd.det_ld = 1'b1;
            S_DIVLD: begin
                o_cmd.minor_idx = {r_mi[1:0], r_mi[3:2]};
                o_cmd.flip      = r_mi[0] ^ r_mi[2];
                o_cmd.last      = r_mi == 4'd15;
                if (i_stat.det_zero) begin
                    o_cmd.out_sing = 1'b1;
                end else begin
                    o_cmd.div_ld = 1'b1;
                end
            end
            S_DCHK: o_cmd.div_chk = 1'b1;
            S_DIT:  o_cmd.div_it  = 1'b1;
            S_DFIN: begin
                o_cmd.div_fin = 1'b1;
                o_cmd.last    = r_mi == 4'd15;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_mode  <= MD_MUL1;
            r_cnt   <= 4'd0;
            r_mi    <= 4'd0;
            r_term  <= 3'd0;
            r_it    <= 5'd0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_mi    <= n_mi;
            r_term  <= n_term;
            r_it    <= n_it;
        end
    end

    `M4_ASSERT_IMP(a_rd_no_wr, i_clk, i_rst_n, o_cmd.rd_en, !o_cmd.wr_en)
    `M4_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, o_cmd.wr_en && (r_cnt == 4'd15), r_state == S_LOAD)
    `M4_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT) && i_stall, (r_state == S_OUT) && $stable(r_mi))

endmodule

`default_nettype wire
